// ===== src/closest_point_on_segment_3d_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the closest-point unit
// Shared property forms; every use samples on clk, and all but the raw form are gated by rst.
// ----------------------------------------------------------------------------
`ifndef CLOSEST_POINT_ON_SEGMENT_3D_UNIT_DEFINES_SVH
`define CLOSEST_POINT_ON_SEGMENT_3D_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define CPS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("closest point unit: property failed");

// antecedent implies consequent in the next cycle
`define CPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("closest point unit: property failed");

// checked also while reset is applied
`define CPS_ASSERT_RAW(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("closest point unit: property failed");

`endif

// ===== src/cps_pkg.sv =====
// ----------------------------------------------------------------------------
// cps_pkg
// Shared constants and types of the closest-point unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cps_pkg;

  localparam int COORD_WIDTH_DEF = 32;

  typedef enum logic [1:0] {
    CASE_INTERIOR = 2'd0,
    CASE_START    = 2'd1,
    CASE_END      = 2'd2
  } case_t;

  // per-stage control travelling with each item
  typedef struct packed {
    logic  valid;
    case_t kind;
  } ctrl_t;

endpackage

`default_nettype wire

// ===== src/closest_point_on_segment_3d_unit.sv =====
// ----------------------------------------------------------------------------
// closest_point_on_segment_3d_unit
// Closest point on a 3D segment to a query point, signed Q16.16, exact.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one transfer carries start, end and point (x, y, z each).
//   Output stream m_*: one transfer per input, the nearest point in tdata and
//   the case code in tuser (interior, clamped to start, clamped to end).
//   Throughput: one item per cycle while m_tready holds. The quotient is
//   formed by a row of COORD_WIDTH+1 division cells, one quotient bit of
//   |d|*s/L per cell, each cell handing its partial remainder to the next
//   every cycle that it is not stalled. Three front stages, the cell row and
//   one output register lie between input transfer and output valid.
//   Reset clears all valid bits; no item is in flight afterwards.
//   When the receiver stalls, items pack into empty stages; s_tready drops
//   only when every stage up to the input holds an item.
// ----------------------------------------------------------------------------
`default_nettype none

module closest_point_on_segment_3d_unit import cps_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   s_tvalid,
  output logic                                        s_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z, point_x, point_y, point_z
  input  wire logic [((9*COORD_WIDTH+7)/8)*8-1:0]     s_tdata,
  output logic                                        m_tvalid,
  input  wire logic                                   m_tready,
  // near_x, near_y, near_z
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0]          m_tdata,
  // which_case
  output logic [1:0]                                  m_tuser
);

  `include "closest_point_on_segment_3d_unit_defines.svh"

  localparam int W     = COORD_WIDTH;
  localparam int LW    = 2 * W + 2;
  localparam int NCELL = W + 1;
  localparam int OW    = ((3 * W + 7) / 8) * 8;

  logic [2:0][W-1:0] in_start, in_end, in_point;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      in_start[k] = s_tdata[k*W +: W];
      in_end[k]   = s_tdata[(3+k)*W +: W];
      in_point[k] = s_tdata[(6+k)*W +: W];
    end
  end

  // node i feeds cell i; node NCELL is the last cell's output
  ctrl_t             n_ctrl  [NCELL+1];
  logic              n_ready [NCELL+1];
  logic [2:0][W-1:0] n_start [NCELL+1];
  logic [2:0][W-1:0] n_end   [NCELL+1];
  logic [2:0]        n_neg   [NCELL+1];
  logic [2:0][W:0]   n_mag   [NCELL+1];
  logic [LW-1:0]     n_s     [NCELL+1];
  logic [LW-1:0]     n_len   [NCELL+1];
  logic [2:0][LW-1:0] n_r    [NCELL+1];
  logic [2:0][W:0]   n_q     [NCELL+1];

  cps_front #(.W(W)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .start_p   (in_start),
    .end_p     (in_end),
    .point_p   (in_point),
    .out_ctrl  (n_ctrl[0]),
    .out_ready (n_ready[0]),
    .out_start (n_start[0]),
    .out_end   (n_end[0]),
    .out_neg   (n_neg[0]),
    .out_mag   (n_mag[0]),
    .out_s     (n_s[0]),
    .out_len   (n_len[0])
  );

  assign n_r[0] = '0;
  assign n_q[0] = '0;

  // cell i takes magnitude bit W-i: most significant bit first
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    cps_cell #(.W(W), .BIT(W - i)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_ctrl   (n_ctrl[i]),
      .in_ready  (n_ready[i]),
      .in_start  (n_start[i]),
      .in_end    (n_end[i]),
      .in_neg    (n_neg[i]),
      .in_mag    (n_mag[i]),
      .in_s      (n_s[i]),
      .in_len    (n_len[i]),
      .in_r      (n_r[i]),
      .in_q      (n_q[i]),
      .out_ctrl  (n_ctrl[i+1]),
      .out_ready (n_ready[i+1]),
      .out_start (n_start[i+1]),
      .out_end   (n_end[i+1]),
      .out_neg   (n_neg[i+1]),
      .out_mag   (n_mag[i+1]),
      .out_s     (n_s[i+1]),
      .out_len   (n_len[i+1]),
      .out_r     (n_r[i+1]),
      .out_q     (n_q[i+1])
    );
  end

  // output register
  logic              out_load;
  logic [2:0][W-1:0] near_next;

  assign out_load        = !m_tvalid || m_tready;
  assign n_ready[NCELL]  = out_load;

  always_comb begin
    logic [W-1:0] qv;
    for (int k = 0; k < 3; k++) begin
      qv = n_q[NCELL][k][W-1:0];
      case (n_ctrl[NCELL].kind)
        CASE_START: near_next[k] = n_start[NCELL][k];
        CASE_END:   near_next[k] = n_end[NCELL][k];
        default:    near_next[k] = n_start[NCELL][k] + (n_neg[NCELL][k] ? (~qv + 1'b1) : qv);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= n_ctrl[NCELL].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {{(OW - 3*W){1'b0}}, near_next[2], near_next[1], near_next[0]};
      m_tuser <= n_ctrl[NCELL].kind;
    end
  end

  `CPS_ASSERT_SAME(a_case_code, m_tvalid, m_tuser != 2'd3)
  `CPS_ASSERT_SAME(a_ready_when_drained, !m_tvalid, s_tready)
  `CPS_ASSERT_NEXT(a_hold_on_stall, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `CPS_ASSERT_RAW(a_reset_clears, $past(rst), !m_tvalid)

endmodule

`default_nettype wire

// ===== src/cps_front.sv =====
// ----------------------------------------------------------------------------
// cps_front
// Differences, six products, dot sums and case decision over three stages.
// ----------------------------------------------------------------------------
`default_nettype none

module cps_front import cps_pkg::*; #(
  parameter int W = COORD_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [2:0][W-1:0]      start_p,
  input  wire logic [2:0][W-1:0]      end_p,
  input  wire logic [2:0][W-1:0]      point_p,
  output ctrl_t                       out_ctrl,
  input  wire logic                   out_ready,
  output logic [2:0][W-1:0]           out_start,
  output logic [2:0][W-1:0]           out_end,
  output logic [2:0]                  out_neg,
  output logic [2:0][W:0]             out_mag,
  output logic [2*W+1:0]              out_s,
  output logic [2*W+1:0]              out_len
);

  localparam int LW = 2 * W + 2;
  localparam int SW = 2 * W + 4;

  // stage A
  logic                   va;
  logic [2:0][W-1:0]      a_start, a_end;
  logic [2:0][W:0]        a_d, a_q;
  // stage B
  logic                   vb;
  logic [2:0][W-1:0]      b_start, b_end;
  logic [2:0][W:0]        b_d;
  logic [2:0][LW-1:0]     b_dq, b_dd;
  // stage C
  logic                   vc;
  case_t                  c_kind;

  logic rdy_a, rdy_b, rdy_c;

  assign rdy_c    = !vc || out_ready;
  assign rdy_b    = !vb || rdy_c;
  assign rdy_a    = !va || rdy_b;
  assign in_ready = rdy_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      if (rdy_a) va <= in_valid;
      if (rdy_b) vb <= va;
      if (rdy_c) vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      for (int k = 0; k < 3; k++) begin
        a_start[k] <= start_p[k];
        a_end[k]   <= end_p[k];
        a_d[k]     <= {end_p[k][W-1], end_p[k]} - {start_p[k][W-1], start_p[k]};
        a_q[k]     <= {point_p[k][W-1], point_p[k]} - {start_p[k][W-1], start_p[k]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_b) begin
      for (int k = 0; k < 3; k++) begin
        b_start[k] <= a_start[k];
        b_end[k]   <= a_end[k];
        b_d[k]     <= a_d[k];
        b_dq[k]    <= $signed(a_d[k]) * $signed(a_q[k]);
        b_dd[k]    <= $signed(a_d[k]) * $signed(a_d[k]);
      end
    end
  end

  logic signed [SW-1:0] s_sum;
  logic [LW-1:0]        l_sum;
  case_t                kind_next;

  always_comb begin
    s_sum = {{2{b_dq[0][LW-1]}}, b_dq[0]} + {{2{b_dq[1][LW-1]}}, b_dq[1]}
          + {{2{b_dq[2][LW-1]}}, b_dq[2]};
    // squares are nonnegative and their sum stays below 2^LW
    l_sum = b_dd[0] + b_dd[1] + b_dd[2];
    if (s_sum[SW-1] || (s_sum == '0)) kind_next = CASE_START;
    else if (s_sum >= $signed({2'b00, l_sum})) kind_next = CASE_END;
    else kind_next = CASE_INTERIOR;
  end

  always_ff @(posedge clk) begin
    if (rdy_c) begin
      c_kind  <= kind_next;
      out_s   <= s_sum[LW-1:0];
      out_len <= l_sum;
      for (int k = 0; k < 3; k++) begin
        out_start[k] <= b_start[k];
        out_end[k]   <= b_end[k];
        out_neg[k]   <= b_d[k][W];
        out_mag[k]   <= b_d[k][W] ? (~b_d[k] + 1'b1) : b_d[k];
      end
    end
  end

  assign out_ctrl.valid = vc;
  assign out_ctrl.kind  = c_kind;

endmodule

`default_nettype wire

// ===== src/cps_cell.sv =====
// ----------------------------------------------------------------------------
// cps_cell
// One radix-2 step of the scaled division |d|*s/L, three lanes wide.
// ----------------------------------------------------------------------------
`default_nettype none

module cps_cell import cps_pkg::*; #(
  parameter int W   = COORD_WIDTH_DEF,
  parameter int BIT = 0
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  ctrl_t                       in_ctrl,
  output logic                        in_ready,
  input  wire logic [2:0][W-1:0]      in_start,
  input  wire logic [2:0][W-1:0]      in_end,
  input  wire logic [2:0]             in_neg,
  input  wire logic [2:0][W:0]        in_mag,
  input  wire logic [2*W+1:0]         in_s,
  input  wire logic [2*W+1:0]         in_len,
  input  wire logic [2:0][2*W+1:0]    in_r,
  input  wire logic [2:0][W:0]        in_q,
  output ctrl_t                       out_ctrl,
  input  wire logic                   out_ready,
  output logic [2:0][W-1:0]           out_start,
  output logic [2:0][W-1:0]           out_end,
  output logic [2:0]                  out_neg,
  output logic [2:0][W:0]             out_mag,
  output logic [2*W+1:0]              out_s,
  output logic [2*W+1:0]              out_len,
  output logic [2:0][2*W+1:0]         out_r,
  output logic [2:0][W:0]             out_q
);

  localparam int LW = 2 * W + 2;
  localparam int XW = LW + 3;

  logic [2:0][LW-1:0] r_next;
  logic [2:0][W:0]    q_next;

  assign in_ready = !out_ctrl.valid || out_ready;

  // remainder stays below L, so 2r + s < 3L: digit is 0, 1 or 2
  always_comb begin
    logic [XW-1:0] rr, t1, t2;
    for (int k = 0; k < 3; k++) begin
      rr = {{2{1'b0}}, in_r[k], 1'b0} + (in_mag[k][BIT] ? {3'b000, in_s} : '0);
      t1 = rr - {3'b000, in_len};
      t2 = rr - {2'b00, in_len, 1'b0};
      if (!t2[XW-1]) begin
        r_next[k] = t2[LW-1:0];
        q_next[k] = {in_q[k][W-1:0], 1'b0} + (W+1)'(2);
      end else if (!t1[XW-1]) begin
        r_next[k] = t1[LW-1:0];
        q_next[k] = {in_q[k][W-1:0], 1'b1};
      end else begin
        r_next[k] = rr[LW-1:0];
        q_next[k] = {in_q[k][W-1:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctrl.valid <= 1'b0;
    end else if (in_ready) begin
      out_ctrl.valid <= in_ctrl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_ctrl.kind <= in_ctrl.kind;
      out_start     <= in_start;
      out_end       <= in_end;
      out_neg       <= in_neg;
      out_mag       <= in_mag;
      out_s         <= in_s;
      out_len       <= in_len;
      out_r         <= r_next;
      out_q         <= q_next;
    end
  end

endmodule

`default_nettype wire

// ===== test/closest_point_on_segment_3d_checker.sv =====
// ----------------------------------------------------------------------------
// closest_point_on_segment_3d_checker
// Watches both streams of the closest-point unit, predicts each nearest point
// and compares the results in order.
// ----------------------------------------------------------------------------
`default_nettype none

module closest_point_on_segment_3d_checker import cps_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  input  wire logic         s_tready,
  input  wire logic [287:0] s_tdata,
  input  wire logic         m_tvalid,
  input  wire logic         m_tready,
  input  wire logic [95:0]  m_tdata,
  input  wire logic [1:0]   m_tuser,
  output int                errors,
  output int                pending
);

  typedef struct {
    logic [31:0] near [3];
    case_t       kind;
  } nearest_t;

  nearest_t nearest_q[$];

  // exact projection; 192-bit signed math holds every product without loss
  function automatic nearest_t project_point(logic [287:0] item);
    nearest_t           r;
    logic signed [191:0] st [3];
    logic signed [191:0] en [3];
    logic signed [191:0] pt [3];
    logic signed [191:0] s;
    logic signed [191:0] len2;
    logic signed [191:0] num;
    logic signed [191:0] quo;
    logic signed [191:0] sum;
    logic                neg;
    s    = '0;
    len2 = '0;
    for (int k = 0; k < 3; k++) begin
      st[k] = $signed(item[32*k +: 32]);
      en[k] = $signed(item[32*(k+3) +: 32]);
      pt[k] = $signed(item[32*(k+6) +: 32]);
      s     = s + (en[k] - st[k]) * (pt[k] - st[k]);
      len2  = len2 + (en[k] - st[k]) * (en[k] - st[k]);
    end
    if (s <= 0) begin
      for (int k = 0; k < 3; k++) r.near[k] = st[k][31:0];
      r.kind = CASE_START;
    end else if (s >= len2) begin
      for (int k = 0; k < 3; k++) r.near[k] = en[k][31:0];
      r.kind = CASE_END;
    end else begin
      for (int k = 0; k < 3; k++) begin
        num = (en[k] - st[k]) * s;
        neg = num < 0;
        if (neg) num = -num;
        quo = num / len2;  // both positive: truncation toward zero
        if (neg) quo = -quo;
        sum = st[k] + quo;
        r.near[k] = sum[31:0];
      end
      r.kind = CASE_INTERIOR;
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    nearest_t e;
    int       fails;
    fails = 0;
    if (rst) begin
      errors  <= 0;
      pending <= 0;
    end else begin
      if (s_tvalid && s_tready) nearest_q.push_back(project_point(s_tdata));
      if (m_tvalid && m_tready) begin
        if (nearest_q.size() == 0) begin
          $display("%0t: unexpected result %h case %0d", $time, m_tdata, m_tuser);
          fails = fails + 1;
        end else begin
          e = nearest_q.pop_front();
          for (int k = 0; k < 3; k++)
            if (m_tdata[32*k +: 32] !== e.near[k]) begin
              $display("%0t: near[%0d] expected %h actual %h", $time, k, e.near[k],
                       m_tdata[32*k +: 32]);
              fails = fails + 1;
            end
          if (m_tuser !== e.kind) begin
            $display("%0t: which_case expected %0d actual %0d", $time, e.kind, m_tuser);
            fails = fails + 1;
          end
        end
      end
      errors  <= errors + fails;
      pending <= nearest_q.size();
    end
  end

endmodule

`default_nettype wire

// ===== test/tb_closest_point_on_segment_3d_unit.sv =====
// ----------------------------------------------------------------------------
// tb_closest_point_on_segment_3d_unit
// Drives segment/point queries into the closest-point unit under random
// idling and back-pressure; a checker module predicts and compares results.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_closest_point_on_segment_3d_unit import cps_pkg::*;;

  localparam int RAND_ITEMS = 1800;
  localparam int DRAIN      = 60;      // exceeds the pipeline latency
  localparam int LIMIT      = 300000;  // cycles

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [287:0] s_tdata = '0;  // sx, sy, sz, ex, ey, ez, px, py, pz
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [95:0]  m_tdata;       // near_x, near_y, near_z
  logic [1:0]   m_tuser;       // which_case
  int           errors;
  int           pending;
  int           send_idle_pct = 36;
  int           recv_stall_pct = 51;
  logic         hold_start = 1'b0;
  logic         hold = 1'b0;
  int           cycles = 0;

  always #6 clk = ~clk;

  closest_point_on_segment_3d_unit dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser
  );

  closest_point_on_segment_3d_checker chk (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .errors, .pending
  );

  // receiver: random stalls, or a long hold-off while hold is set
  always @(posedge clk)
    m_tready <= !hold && ($urandom_range(99) >= recv_stall_pct);

  // long receiver hold-off, counted here; the pipe fills and s_tready drops
  initial begin
    wait (hold_start);
    @(posedge clk);
    hold <= 1'b1;
    repeat (300) @(posedge clk);
    hold <= 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL closest_point_on_segment_3d_unit");
      $finish;
    end
  end

  // one transfer; called at a rising edge, returns at the accepting edge
  task automatic send_query(input logic [31:0] sx, sy, sz, ex, ey, ez, px, py, pz);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {pz, py, px, ez, ey, ex, sz, sy, sx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // coordinate of random scale: full range, moderate, or tiny
  function automatic logic [31:0] rand_coord(int scale);
    case (scale)
      0:       return $urandom;
      1:       return $urandom_range(32'h0100_0000) - 32'h0080_0000;
      default: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
    endcase
  endfunction

  task automatic send_random;
    logic [31:0] sx, sy, sz, ex, ey, ez, px, py, pz;
    int          sc;
    int          t;
    sc = $urandom_range(2);
    sx = rand_coord(sc); sy = rand_coord(sc); sz = rand_coord(sc);
    ex = rand_coord(sc); ey = rand_coord(sc); ez = rand_coord(sc);
    px = rand_coord(sc); py = rand_coord(sc); pz = rand_coord(sc);
    case ($urandom_range(9))
      0: begin ex = sx; ey = sy; ez = sz; end  // degenerate segment
      1: begin px = ex; py = ey; pz = ez; end  // query on the end
      2: begin px = sx; py = sy; pz = sz; end  // query on the start
      3, 4, 5: if (sc != 0) begin
        // query near the segment so most land in the interior
        t  = $urandom_range(255);
        px = sx + (($signed(ex) - $signed(sx)) * t) / 256 + $urandom_range(64) - 32;
        py = sy + (($signed(ey) - $signed(sy)) * t) / 256 + $urandom_range(64) - 32;
        pz = sz + (($signed(ez) - $signed(sz)) * t) / 256 + $urandom_range(64) - 32;
      end
      default: ;
    endcase
    send_query(sx, sy, sz, ex, ey, ez, px, py, pz);
  endtask

  task automatic drain_results;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  localparam logic [31:0] MAXC = 32'h7fff_ffff;
  localparam logic [31:0] MINC = 32'h8000_0000;
  localparam logic [31:0] ONE  = 32'h0001_0000;

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: boundaries, degenerate segment, extremes
    send_query(0, 0, 0, 0, 0, 0, ONE, ONE, ONE);            // zero length
    send_query(0, 0, 0, ONE, 0, 0, 0, ONE, 0);               // s = 0
    send_query(0, 0, 0, ONE, 0, 0, ONE, 5 * ONE, 0);         // s = L
    send_query(0, 0, 0, ONE, 0, 0, -ONE, 0, 0);              // before start
    send_query(0, 0, 0, ONE, 0, 0, 2 * ONE, 0, 0);           // past end
    send_query(0, 0, 0, 3 * ONE, 0, 0, ONE, ONE, 0);         // interior, exact
    send_query(0, 0, 0, -3, -7, 5, -1, -2, 2);               // negative direction
    send_query(MINC, MINC, MINC, MAXC, MAXC, MAXC, 0, 0, 0); // longest diagonal
    send_query(MAXC, MAXC, MAXC, MINC, MINC, MINC, 1, -1, 7);
    send_query(MINC, MAXC, MINC, MAXC, MINC, MAXC, MAXC, MAXC, MAXC);
    send_query(MINC, MINC, MINC, MAXC, MAXC, MAXC, MINC, MINC, MINC);
    send_query(MINC, MINC, MINC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC);
    send_query(MAXC, 0, 0, MINC, 0, 0, 1, 123, MINC);
    send_query(-1, -1, -1, 1, 1, 1, 0, 0, 0);
    send_query(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MINC, MINC, MINC);
    send_query(0, 0, 0, 1, 0, 0, 0, MAXC, MAXC);

    // phase 1: sender idles 36%, receiver 51%; long hold-off part way
    for (int i = 0; i < RAND_ITEMS / 3; i++) begin
      if (i == 100) hold_start <= 1'b1;
      send_random();
    end
    drain_results();  // sender pause until every result is back

    send_idle_pct = 51;
    recv_stall_pct = 36;
    for (int i = 0; i < RAND_ITEMS / 3; i++) send_random();
    drain_results();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < RAND_ITEMS / 3; i++) send_random();
    drain_results();

    repeat (DRAIN) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("PASS closest_point_on_segment_3d_unit");
    else
      $display("FAIL closest_point_on_segment_3d_unit");
    $finish;
  end

endmodule

`default_nettype wire
